### design/ppu_pkg.sv
// shared types, codes and fixed-point helpers for the particle pool update core
package ppu_pkg;

    localparam int POOL_DEPTH_DEF = 1024;
    localparam int CFG_AW         = 1;
    localparam int CFG_DW         = 16;

    localparam logic [CFG_AW-1:0] REG_EMITTING = 1'd0;
    localparam logic [CFG_AW-1:0] REG_RATE     = 1'd1;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_SPAWN = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    localparam logic [1:0] STS_OK   = 2'd0;
    localparam logic [1:0] STS_FULL = 2'd1;
    localparam logic [1:0] STS_MISS = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic [15:0]        size;
        logic [31:0]        age;
        logic [31:0]        lifetime;
        logic [31:0]        halt;
    } particle_t;

    typedef struct packed {
        logic               expired;
        logic [31:0]        age;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
    } slot_eval_t;

    // base + floor(rate * dt / 2^16), saturated to signed 32 bits
    function automatic logic signed [31:0] integ(input logic signed [31:0] base,
                                                 input logic signed [31:0] rate,
                                                 input logic [15:0] dt);
        logic signed [48:0] prod;
        logic signed [33:0] sum;
        logic signed [31:0] res;
        prod = rate * $signed({1'b0, dt});
        sum  = $signed({{2{base[31]}}, base}) + $signed({prod[48], prod[48:16]});
        if (!sum[33] && (sum[32:31] != 2'b00))
            res = 32'sh7fffffff;
        else if (sum[33] && (sum[32:31] != 2'b11))
            res = 32'sh80000000;
        else
            res = sum[31:0];
        return res;
    endfunction

endpackage

### design/particle_pool_update_core.sv
// spawn, unused command and read miss go from idle to done; a read hit passes through a read state first
// tick: eval and write states per surviving live slot, an eval state per removed particle, then done
// one beat at a time: a new beat is taken only in idle, after the walk through the slot memory
// the next beat is taken while a finished result waits in the output register
// reset clears live count, emission accumulator and config; slot memory is not cleared
module particle_pool_update_core
#(
    parameter int POOL_DEPTH = ppu_pkg::POOL_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ppu_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [ppu_pkg::CFG_DW-1:0] cfg_wdata,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [1:0]                 command,
    input  logic [15:0]                dt,
    input  logic signed [31:0]         pos_x,
    input  logic signed [31:0]         pos_y,
    input  logic signed [31:0]         vel_x,
    input  logic signed [31:0]         vel_y,
    input  logic signed [31:0]         acc_x,
    input  logic signed [31:0]         acc_y,
    input  logic [15:0]                size,
    input  logic [31:0]                lifetime,
    input  logic [31:0]                halt_time,
    input  logic [9:0]                 entry_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 status,
    output logic [10:0]                active_count,
    output logic [15:0]                spawn_due,
    output logic signed [31:0]         out_pos_x,
    output logic signed [31:0]         out_pos_y,
    output logic [15:0]                out_size
);
    import ppu_pkg::*;

    localparam int AW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);
    localparam int IW = (CW > 10) ? CW : 11;

    particle_t mem [POOL_DEPTH];
    particle_t rd_data_reg;
    particle_t mem_wdata;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] rd_addr;
    logic mem_we;

    state_t state_reg, state_next;
    logic [CW-1:0] live_reg, live_next;
    logic [15:0] acc_reg, acc_next;
    logic emitting_reg;
    logic [15:0] rate_reg;
    logic [15:0] dt_reg, dt_next;
    logic [AW-1:0] slot_reg, slot_next;
    particle_t rec_reg, rec_next;
    logic [1:0] res_status_reg, res_status_next;
    logic [15:0] res_due_reg, res_due_next;
    logic signed [31:0] res_x_reg, res_x_next, res_y_reg, res_y_next;
    logic [15:0] res_size_reg, res_size_next;
    logic out_valid_reg;
    logic [1:0] out_status_reg;
    logic [10:0] out_count_reg;
    logic [15:0] out_due_reg, out_size_reg;
    logic signed [31:0] out_x_reg, out_y_reg;

    slot_eval_t ev;
    logic accept, out_free, read_hit, slot_is_last, more_slots;
    logic [31:0] emit_prod;
    logic [32:0] emit_sum;
    logic [31:0] emit_sat;

    ppu_slot_alu u_slot_alu
    (
        .rec (rd_data_reg),
        .dt  (dt_reg),
        .ev  (ev)
    );

    assign in_ready     = (state_reg == ST_IDLE);
    assign accept       = in_valid && in_ready;
    assign out_free     = !out_valid_reg || out_ready;
    assign read_hit     = IW'(entry_index) < IW'(live_reg);
    assign slot_is_last = (CW'(slot_reg) == (live_reg - CW'(1)));
    assign more_slots   = ((CW'(slot_reg) + CW'(1)) < live_reg);
    assign emit_prod    = dt * rate_reg;
    assign emit_sum     = {17'b0, acc_reg} + {1'b0, emit_prod};
    assign emit_sat     = emit_sum[32] ? 32'hffffffff : emit_sum[31:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (command)
                        CMD_TICK: state_next = (live_reg == '0) ? ST_DONE : ST_EVAL;
                        CMD_READ: state_next = read_hit ? ST_READ : ST_DONE;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_EVAL:
            begin
                if (ev.expired)
                    state_next = slot_is_last ? ST_DONE : ST_EVAL;
                else
                    state_next = ST_WRITE;
            end
            ST_WRITE: state_next = more_slots ? ST_EVAL : ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        live_next       = live_reg;
        acc_next        = acc_reg;
        dt_next         = dt_reg;
        slot_next       = slot_reg;
        rec_next        = rec_reg;
        res_status_next = res_status_reg;
        res_due_next    = res_due_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        res_size_next   = res_size_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_reg;
        mem_wdata       = rec_reg;
        rd_addr         = slot_reg + AW'(1);
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = (command == CMD_READ) ? AW'(entry_index) : '0;
                if (accept)
                begin
                    dt_next         = dt;
                    slot_next       = '0;
                    res_status_next = STS_OK;
                    res_due_next    = '0;
                    res_x_next      = '0;
                    res_y_next      = '0;
                    res_size_next   = '0;
                    case (command)
                        CMD_TICK:
                        begin
                            if (emitting_reg)
                            begin
                                res_due_next = emit_sat[31:16];
                                acc_next     = emit_sat[15:0];
                            end
                        end
                        CMD_SPAWN:
                        begin
                            if (live_reg < CW'(POOL_DEPTH))
                            begin
                                mem_we             = 1'b1;
                                mem_waddr          = AW'(live_reg);
                                mem_wdata.pos_x    = pos_x;
                                mem_wdata.pos_y    = pos_y;
                                mem_wdata.vel_x    = vel_x;
                                mem_wdata.vel_y    = vel_y;
                                mem_wdata.acc_x    = acc_x;
                                mem_wdata.acc_y    = acc_y;
                                mem_wdata.size     = size;
                                mem_wdata.age      = '0;
                                mem_wdata.lifetime = lifetime;
                                mem_wdata.halt     = halt_time;
                                live_next          = live_reg + CW'(1);
                            end
                            else
                                res_status_next = STS_FULL;
                        end
                        CMD_READ:
                        begin
                            if (!read_hit)
                                res_status_next = STS_MISS;
                        end
                        default: ;
                    endcase
                end
            end
            ST_EVAL:
            begin
                // an expired slot takes the last live particle, which is checked next
                rd_addr = AW'(live_reg - CW'(1));
                if (ev.expired)
                    live_next = live_reg - CW'(1);
                else
                begin
                    rec_next       = rd_data_reg;
                    rec_next.age   = ev.age;
                    rec_next.vel_x = ev.vel_x;
                    rec_next.vel_y = ev.vel_y;
                    rec_next.acc_x = ev.acc_x;
                    rec_next.acc_y = ev.acc_y;
                end
            end
            ST_WRITE:
            begin
                mem_we          = 1'b1;
                mem_wdata.pos_x = integ(rec_reg.pos_x, rec_reg.vel_x, dt_reg);
                mem_wdata.pos_y = integ(rec_reg.pos_y, rec_reg.vel_y, dt_reg);
                slot_next       = slot_reg + AW'(1);
            end
            ST_READ:
            begin
                res_x_next    = rd_data_reg.pos_x;
                res_y_next    = rd_data_reg.pos_y;
                res_size_next = rd_data_reg.size;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        dt_reg         <= dt_next;
        slot_reg       <= slot_next;
        rec_reg        <= rec_next;
        res_status_reg <= res_status_next;
        res_due_reg    <= res_due_next;
        res_x_reg      <= res_x_next;
        res_y_reg      <= res_y_next;
        res_size_reg   <= res_size_next;
        if (state_reg == ST_DONE && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_count_reg  <= 11'(live_reg);
            out_due_reg    <= res_due_reg;
            out_x_reg      <= res_x_reg;
            out_y_reg      <= res_y_reg;
            out_size_reg   <= res_size_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            live_reg      <= '0;
            acc_reg       <= '0;
            emitting_reg  <= 1'b0;
            rate_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            live_reg  <= live_next;
            acc_reg   <= acc_next;
            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_EMITTING: emitting_reg <= cfg_wdata[0];
                    REG_RATE:     rate_reg     <= cfg_wdata;
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign active_count = out_count_reg;
    assign spawn_due    = out_due_reg;
    assign out_pos_x    = out_x_reg;
    assign out_pos_y    = out_y_reg;
    assign out_size     = out_size_reg;

    a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= CW'(POOL_DEPTH))
        else $error("live count above pool depth");

    a_tick_no_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EVAL || state_reg == ST_WRITE) |=> live_reg <= $past(live_reg))
        else $error("live count grew during tick walk");

    a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EVAL |-> CW'(slot_reg) < live_reg)
        else $error("tick walk slot beyond live particles");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STS_MISS) |-> (out_pos_x == 0 && out_size == 0))
        else $error("read miss carries data");

endmodule

### design/ppu_slot_alu.sv
// per-slot tick update: aging, expiry and halt checks, velocity step
module ppu_slot_alu
(
    input  ppu_pkg::particle_t  rec,
    input  logic [15:0]         dt,
    output ppu_pkg::slot_eval_t ev
);
    import ppu_pkg::*;

    logic [32:0] age_sum;
    logic [31:0] age_new;
    logic        halted;

    always_comb
    begin
        age_sum = {1'b0, rec.age} + {17'b0, dt};
        age_new = age_sum[32] ? 32'hffffffff : age_sum[31:0];
        halted  = age_new > rec.halt;
        ev.expired = age_new > rec.lifetime;
        ev.age     = age_new;
        if (halted)
        begin
            ev.vel_x = '0;
            ev.vel_y = '0;
            ev.acc_x = '0;
            ev.acc_y = '0;
        end
        else
        begin
            ev.vel_x = integ(rec.vel_x, rec.acc_x, dt);
            ev.vel_y = integ(rec.vel_y, rec.acc_y, dt);
            ev.acc_x = rec.acc_x;
            ev.acc_y = rec.acc_y;
        end
    end

endmodule

### dv/particle_pool_update_core_tb.sv
// testbench for the particle pool update core: directed and random commands vs a predictor
`timescale 1ns / 1ps

module particle_pool_update_core_tb;
    import ppu_pkg::*;

    localparam int DEPTH = 1024;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]         cmd;
        logic [15:0]        step;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic [15:0]        sz;
        logic [31:0]        life;
        logic [31:0]        halt;
        logic [9:0]         idx;
    } command_beat_t;

    typedef struct {
        logic [1:0]  sts;
        logic [10:0] count;
        logic [15:0] due;
        logic [31:0] rx;
        logic [31:0] ry;
        logic [15:0] rsz;
    } pool_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;
    logic in_valid;
    logic in_ready;
    logic [1:0] command;
    logic [15:0] dt;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
    logic [15:0] size;
    logic [31:0] lifetime;
    logic [31:0] halt_time;
    logic [9:0] entry_index;
    logic out_valid;
    logic out_ready;
    logic [1:0] status;
    logic [10:0] active_count;
    logic [15:0] spawn_due;
    logic signed [31:0] out_pos_x, out_pos_y;
    logic [15:0] out_size;

    // shadow pool
    logic signed [31:0] m_px [DEPTH];
    logic signed [31:0] m_py [DEPTH];
    logic signed [31:0] m_vx [DEPTH];
    logic signed [31:0] m_vy [DEPTH];
    logic signed [31:0] m_ax [DEPTH];
    logic signed [31:0] m_ay [DEPTH];
    logic [15:0]        m_sz [DEPTH];
    logic [31:0]        m_age [DEPTH];
    logic [31:0]        m_life [DEPTH];
    logic [31:0]        m_halt [DEPTH];
    int unsigned        live_cnt;
    logic [31:0]        emit_acc;
    logic               emit_on;
    logic [15:0]        emit_rate;

    pool_result_t pending_results[$];
    int errors;
    int burst_left;
    int rx_hold_req;

    particle_pool_update_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(64'd40_000_000);
        $display("== FAIL ==");
        $finish;
    end

    // floor(rate * step / 2^16) added to base, clamped to signed 32 bits
    function automatic logic signed [31:0] advance(input logic signed [31:0] base,
                                                   input logic signed [31:0] rate,
                                                   input logic [15:0] step);
        longint prod;
        longint sum;
        prod = longint'(rate) * longint'({1'b0, step});
        sum  = longint'(base) + (prod >>> 16);
        if (sum > 64'sd2147483647)
            sum = 64'sd2147483647;
        if (sum < -64'sd2147483648)
            sum = -64'sd2147483648;
        return sum[31:0];
    endfunction

    function automatic pool_result_t predict_pool(input command_beat_t b);
        pool_result_t r;
        longint unsigned a;
        int unsigned i;
        int unsigned last;
        r = '{default: '0};
        if (b.cmd == CMD_TICK)
        begin
            if (emit_on)
            begin
                a = longint'(emit_acc) + longint'(b.step) * longint'(emit_rate);
                if (a > 64'hFFFF_FFFF)
                    a = 64'hFFFF_FFFF;
                r.due = a[31:16];
                emit_acc = {16'h0, a[15:0]};
            end
            for (i = 0; i < live_cnt; i++)
            begin
                a = longint'(m_age[i]) + b.step;
                m_age[i] = (a > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : a[31:0];
            end
            i = 0;
            while (i < live_cnt)
            begin
                if (m_age[i] > m_life[i])
                begin
                    // swap last into the hole and look at it again
                    last = live_cnt - 1;
                    m_px[i] = m_px[last];   m_py[i] = m_py[last];
                    m_vx[i] = m_vx[last];   m_vy[i] = m_vy[last];
                    m_ax[i] = m_ax[last];   m_ay[i] = m_ay[last];
                    m_sz[i] = m_sz[last];   m_age[i] = m_age[last];
                    m_life[i] = m_life[last]; m_halt[i] = m_halt[last];
                    live_cnt--;
                end
                else
                    i++;
            end
            for (i = 0; i < live_cnt; i++)
            begin
                if (m_age[i] > m_halt[i])
                begin
                    m_vx[i] = '0; m_vy[i] = '0; m_ax[i] = '0; m_ay[i] = '0;
                end
                m_vx[i] = advance(m_vx[i], m_ax[i], b.step);
                m_vy[i] = advance(m_vy[i], m_ay[i], b.step);
                m_px[i] = advance(m_px[i], m_vx[i], b.step);
                m_py[i] = advance(m_py[i], m_vy[i], b.step);
            end
        end
        else if (b.cmd == CMD_SPAWN)
        begin
            if (live_cnt < DEPTH)
            begin
                m_px[live_cnt] = b.px;  m_py[live_cnt] = b.py;
                m_vx[live_cnt] = b.vx;  m_vy[live_cnt] = b.vy;
                m_ax[live_cnt] = b.ax;  m_ay[live_cnt] = b.ay;
                m_sz[live_cnt] = b.sz;  m_age[live_cnt] = '0;
                m_life[live_cnt] = b.life;
                m_halt[live_cnt] = b.halt;
                live_cnt++;
            end
            else
                r.sts = STS_FULL;
        end
        else if (b.cmd == CMD_READ)
        begin
            if (b.idx < live_cnt)
            begin
                r.rx = m_px[b.idx];
                r.ry = m_py[b.idx];
                r.rsz = m_sz[b.idx];
            end
            else
                r.sts = STS_MISS;
        end
        r.count = live_cnt[10:0];
        return r;
    endfunction

    // sender: bursts with random gaps, predicts on acceptance
    task automatic send_beat(input command_beat_t b);
        if (burst_left == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        command = b.cmd;   dt = b.step;
        pos_x = b.px;      pos_y = b.py;
        vel_x = b.vx;      vel_y = b.vy;
        acc_x = b.ax;      acc_y = b.ay;
        size = b.sz;       lifetime = b.life;
        halt_time = b.halt; entry_index = b.idx;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_pool(b));
        @(negedge clk);
    endtask

    task automatic drain;
        in_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] a, input logic [CFG_DW-1:0] d);
        cfg_we = 1'b1;
        cfg_addr = a;
        cfg_wdata = d;
        if (a == REG_EMITTING)
            emit_on = d[0];
        else
            emit_rate = d;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic command_beat_t plain(input logic [1:0] c);
        command_beat_t b;
        b = '{default: '0};
        b.cmd = c;
        return b;
    endfunction

    function automatic logic signed [31:0] rand_motion();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            2: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic command_beat_t rand_spawn(input bit short_life);
        command_beat_t b;
        b = plain(CMD_SPAWN);
        b.px = $urandom();   b.py = $urandom();
        b.vx = rand_motion(); b.vy = rand_motion();
        b.ax = rand_motion(); b.ay = rand_motion();
        b.sz = 16'($urandom());
        b.idx = 10'($urandom());
        b.step = 16'($urandom());
        if (short_life || $urandom_range(0, 7) != 0)
            b.life = $urandom_range(0, 32'h0004_0000);
        else
            b.life = $urandom();
        b.halt = $urandom_range(0, 1) ? $urandom_range(0, b.life) : $urandom();
        return b;
    endfunction

    function automatic command_beat_t rand_beat();
        command_beat_t b;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 38)
            b = rand_spawn(live_cnt > 80);
        else if (pick < 62)
        begin
            b = plain(CMD_TICK);
            b.step = $urandom_range(0, 1) ? 16'($urandom())
                                          : 16'($urandom_range(0, 16'h0800));
            b.px = $urandom();
        end
        else if (pick < 96)
        begin
            b = plain(CMD_READ);
            if ($urandom_range(0, 4) == 0 || live_cnt == 0)
                b.idx = 10'($urandom());
            else
                b.idx = 10'($urandom_range(0, live_cnt - 1));
        end
        else
        begin
            b = rand_spawn(1'b1);
            b.cmd = CMD_UNUSED;
        end
        return b;
    endfunction

    task automatic test_directed;
        command_beat_t b;
        int k;
        write_reg(REG_EMITTING, 16'd1);
        write_reg(REG_RATE, 16'hFFFF);
        b = plain(CMD_SPAWN);
        b.px = 32'sh7fff_ffff; b.py = 32'sh8000_0000;
        b.vx = 32'sh7fff_ffff; b.vy = 32'sh8000_0000;
        b.ax = 32'sh7fff_ffff; b.ay = 32'sh8000_0000;
        b.sz = 16'hFFFF; b.life = 32'hFFFF_FFFF; b.halt = 32'hFFFF_FFFF;
        send_beat(b);
        // dies on the first nonzero step
        send_beat(plain(CMD_SPAWN));
        b = plain(CMD_SPAWN);
        b.vx = -32'sd1; b.ax = 32'sd1; b.sz = 16'h1234;
        b.life = 32'h0003_0000; b.halt = 32'h0000_8000;
        send_beat(b);
        for (k = 0; k < 4; k++)
        begin
            b = plain(CMD_READ);
            b.idx = 10'(k);
            send_beat(b);
        end
        b.idx = 10'h3FF;
        send_beat(b);
        b = rand_spawn(1'b0);
        b.cmd = CMD_UNUSED;
        send_beat(b);
        send_beat(plain(CMD_TICK));
        b = plain(CMD_TICK);
        b.step = 16'hFFFF;
        send_beat(b);
        send_beat(b);
        b.step = 16'd1;
        send_beat(b);
        for (k = 0; k < 3; k++)
        begin
            b = plain(CMD_READ);
            b.idx = 10'(k);
            send_beat(b);
        end
        drain();
    endtask

    // fill to the top, overflow, then expire everything by ticks
    task automatic test_pool_full;
        command_beat_t b;
        int k;
        while (live_cnt < DEPTH)
        begin
            b = rand_spawn(1'b1);
            b.life = $urandom_range(0, 32'h0002_0000);
            send_beat(b);
        end
        send_beat(rand_spawn(1'b1));
        send_beat(rand_spawn(1'b1));
        for (k = 0; k < 4; k++)
        begin
            b = plain(CMD_READ);
            b.idx = 10'($urandom());
            send_beat(b);
        end
        b = plain(CMD_TICK);
        b.step = 16'hFFFF;
        for (k = 0; k < 4; k++)
            send_beat(b);
        drain();
    endtask

    task automatic test_backpressure;
        int k;
        drain();
        rx_hold_req = 400;
        for (k = 0; k < 24; k++)
            send_beat(($urandom_range(0, 1) == 0) ? rand_spawn(1'b1) : rand_beat());
        drain();
    endtask

    task automatic test_random;
        int ph;
        int k;
        for (ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0: begin write_reg(REG_EMITTING, 16'd0); write_reg(REG_RATE, 16'($urandom())); end
                1: begin write_reg(REG_EMITTING, 16'd1); write_reg(REG_RATE, 16'd0); end
                2: begin write_reg(REG_EMITTING, 16'd1); write_reg(REG_RATE, 16'hFFFF); end
                default: begin write_reg(REG_EMITTING, 16'd1); write_reg(REG_RATE, 16'($urandom())); end
            endcase
            for (k = 0; k < 110; k++)
                send_beat(rand_beat());
        end
        drain();
    endtask

    // receiver stall patterns plus long hold-off on request
    initial
    begin
        int hold;
        int mode;
        int mode_left;
        hold = 0;
        mode = 0;
        mode_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req > 0)
            begin
                hold = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold > 0)
            begin
                out_ready = 1'b0;
                hold--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0: out_ready = 1'b1;
                    1: out_ready = 1'($urandom_range(0, 1));
                    default: out_ready = ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        pool_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result beat", $time);
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("status", e.sts, status);
                check_field("active_count", e.count, active_count);
                check_field("spawn_due", e.due, spawn_due);
                check_field("out_pos_x", e.rx, out_pos_x);
                check_field("out_pos_y", e.ry, out_pos_y);
                check_field("out_size", e.rsz, out_size);
            end
        end
    end

    initial
    begin
        errors = 0;
        burst_left = 0;
        rx_hold_req = 0;
        live_cnt = 0;
        emit_acc = '0;
        emit_on = 1'b0;
        emit_rate = '0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        command = '0;
        dt = '0;
        pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0; acc_x = '0; acc_y = '0;
        size = '0;
        lifetime = '0;
        halt_time = '0;
        entry_index = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_pool_full();
        test_backpressure();
        test_random();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
